[design/assert_macros.svh]
// Assertion macros for the checker file of the trigger decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, masked while reset is high.
`define CCTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included.
`define CCTD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cctd_pkg.sv]
// Shared constants, codes and control types of the crank and cam trigger decoder.
package cctd_pkg;

  // Zone lookup
  localparam int ZONE_COUNT = 8;
  localparam int ZONE_W     = 3;
  localparam int BYTE_W     = 8;

  // Field widths
  localparam int PERIOD_W = 16;
  localparam int TOOTH_W  = 6;
  localparam int CAM_W    = 8;
  localparam int SEL_W    = 2;

  // Stream widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  // Command codes carried in s_tuser
  localparam logic [1:0] CMD_CRANK    = 2'd0;
  localparam logic [1:0] CMD_CAM      = 2'd1;
  localparam logic [1:0] CMD_THROTTLE = 2'd2;
  localparam logic [1:0] CMD_TABLE    = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_BOUNDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_BOUNDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDEND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_GAP     = 3'd4;

  localparam logic [PERIOD_W-1:0] STALL_RESET    = 16'd10000;
  localparam logic [PERIOD_W-1:0] DIVIDEND_RESET = 16'd55556;
  localparam logic [CAM_W-1:0]    CAM_GAP_RESET  = 8'd20;

  // Tooth positions
  localparam logic [TOOTH_W-1:0] TOOTH_BAD_A  = 6'd13;
  localparam logic [TOOTH_W-1:0] TOOTH_BAD_B  = 6'd16;
  localparam logic [TOOTH_W-1:0] TOOTH_BAD_C  = 6'd31;
  localparam logic [TOOTH_W-1:0] TOOTH_WRAP   = 6'd35;
  localparam logic [TOOTH_W-1:0] TOOTH_WIN_A  = 6'd12;
  localparam logic [TOOTH_W-1:0] TOOTH_WIN_B  = 6'd30;
  localparam logic [TOOTH_W-1:0] TOOTH_IGN_A  = 6'd1;
  localparam logic [TOOTH_W-1:0] TOOTH_IGN_B  = 6'd19;
  localparam logic [TOOTH_W-1:0] TOOTH_INJ_A  = 6'd15;
  localparam logic [TOOTH_W-1:0] TOOTH_INJ_B  = 6'd33;

  // Advance table
  localparam int TABLE_DEPTH = 64;
  localparam int TABLE_AW    = 6;

  // Speed divider and one-third scaling (exact for 16-bit values)
  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int RECIP3_W  = 17;
  localparam logic [RECIP3_W-1:0] RECIP3 = 17'd43691;
  localparam logic [BYTE_W-1:0] HERTZ_MAX = 8'd255;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic update;
    logic zone;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[design/cctd_div.sv]
// Iterative 16-bit restoring divider, one quotient bit per cycle.
module cctd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cctd_pkg::PERIOD_W-1:0]  dividend,
  input  logic [cctd_pkg::PERIOD_W-1:0]  divisor,
  output logic                           done,
  output logic [cctd_pkg::PERIOD_W-1:0]  quotient
);

  logic                           busy;
  logic [cctd_pkg::DIV_CNT_W-1:0] count;
  logic [cctd_pkg::PERIOD_W-1:0]  rem;
  logic [cctd_pkg::PERIOD_W-1:0]  quo;
  logic [cctd_pkg::PERIOD_W-1:0]  dsr;
  logic [cctd_pkg::PERIOD_W+1:0]  diff;
  logic                           fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, rem, quo[cctd_pkg::PERIOD_W-1]} - {2'b00, dsr};
  assign fits = ~diff[cctd_pkg::PERIOD_W+1];

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == cctd_pkg::DIV_CNT_W'(cctd_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift in one quotient bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[cctd_pkg::PERIOD_W-1:0]
                  : {rem[cctd_pkg::PERIOD_W-2:0], quo[cctd_pkg::PERIOD_W-1]};
      quo <= {quo[cctd_pkg::PERIOD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[design/cctd_ctrl.sv]
// Controller state machine that sequences one event through the datapath.
module cctd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  cctd_pkg::status_t sts,
  output cctd_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_DIVIDE = 3'd2;
  localparam logic [2:0] ST_ZONE   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Take a word only while idle
  assign s_tready = (state == ST_IDLE);

  // Decode commands from the state
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && s_tvalid;
    cmd.update = (state == ST_UPDATE);
    cmd.zone   = (state == ST_ZONE);
    cmd.emit   = (state == ST_EMIT) && sts.out_free;
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: if (sts.div_done) state_next = ST_ZONE;
      ST_ZONE:   state_next = ST_EMIT;
      ST_EMIT:   if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/cctd_datapath.sv]
// Datapath: event state, speed divider, zone lookup, advance table and output register.
module cctd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cctd_pkg::cmd_t                      cmd,
  output cctd_pkg::status_t                   sts,
  input  logic [cctd_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [cctd_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cctd_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [cctd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cctd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Lowest zone whose bound lies above the value, else keep the previous zone
  function automatic logic [cctd_pkg::ZONE_W-1:0] pick_zone(
    input logic [cctd_pkg::ZONE_COUNT*cctd_pkg::BYTE_W-1:0] bounds,
    input logic [cctd_pkg::BYTE_W-1:0]                      value,
    input logic [cctd_pkg::ZONE_W-1:0]                      prev
  );
    logic [cctd_pkg::ZONE_W-1:0] zone;
    zone = prev;
    for (int i = cctd_pkg::ZONE_COUNT - 1; i >= 0; i--) begin
      if (value < bounds[i*cctd_pkg::BYTE_W +: cctd_pkg::BYTE_W]) begin
        zone = cctd_pkg::ZONE_W'(i);
      end
    end
    return zone;
  endfunction

  // Configuration registers
  logic [cctd_pkg::CFG_DATA_W-1:0] rpm_bounds;
  logic [cctd_pkg::CFG_DATA_W-1:0] load_bounds;
  logic [cctd_pkg::PERIOD_W-1:0]   stall_period;
  logic [cctd_pkg::PERIOD_W-1:0]   speed_dividend;
  logic [cctd_pkg::CAM_W-1:0]      cam_gap_teeth;

  // Captured input word
  logic [1:0]                      item_cmd;
  logic [cctd_pkg::PERIOD_W-1:0]   item_period;
  logic [cctd_pkg::BYTE_W-1:0]     item_throttle;
  logic [cctd_pkg::TABLE_AW-1:0]   item_index;
  logic [cctd_pkg::BYTE_W-1:0]     item_value;

  // Decoder state
  logic [cctd_pkg::TOOTH_W-1:0]    tooth_count;
  logic [cctd_pkg::CAM_W-1:0]      cam_count;
  logic [cctd_pkg::CAM_W-1:0]      teeth_since_cam;
  logic [cctd_pkg::PERIOD_W-1:0]   last_period;
  logic [cctd_pkg::BYTE_W-1:0]     throttle_level;
  logic [cctd_pkg::ZONE_W-1:0]     speed_band;
  logic [cctd_pkg::ZONE_W-1:0]     load_band;
  logic [cctd_pkg::SEL_W-1:0]      ign_select;
  logic [cctd_pkg::SEL_W-1:0]      inj_select;
  logic                            window;
  logic [cctd_pkg::BYTE_W-1:0]     hertz;

  // Advance table memory with per-entry valid bits
  logic [cctd_pkg::BYTE_W-1:0]     adv_mem [cctd_pkg::TABLE_DEPTH];
  logic [cctd_pkg::TABLE_DEPTH-1:0] adv_valid;
  logic [cctd_pkg::BYTE_W-1:0]     rd_data;
  logic                            rd_valid;

  // Crank step logic
  logic                                     gap;
  logic [cctd_pkg::PERIOD_W+cctd_pkg::RECIP3_W-1:0] third_prod;
  logic [cctd_pkg::PERIOD_W-1:0]            period_new;
  logic [cctd_pkg::PERIOD_W-1:0]            divisor_upd;
  logic [cctd_pkg::TOOTH_W-1:0]             tooth_step;
  logic [cctd_pkg::TOOTH_W-1:0]             tooth_fix;
  logic [cctd_pkg::TOOTH_W-1:0]             tooth_new;
  logic                                     win_hit;

  // Zone stage logic
  logic                            div_done;
  logic [cctd_pkg::PERIOD_W-1:0]   quotient;
  logic [cctd_pkg::BYTE_W-1:0]     hertz_calc;
  logic [cctd_pkg::ZONE_W-1:0]     speed_band_next;
  logic [cctd_pkg::ZONE_W-1:0]     load_band_next;
  logic [cctd_pkg::TABLE_AW-1:0]   rd_addr;
  logic [cctd_pkg::SEL_W-1:0]      ign_select_next;
  logic [cctd_pkg::SEL_W-1:0]      inj_select_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_bounds     <= '0;
      load_bounds    <= '0;
      stall_period   <= cctd_pkg::STALL_RESET;
      speed_dividend <= cctd_pkg::DIVIDEND_RESET;
      cam_gap_teeth  <= cctd_pkg::CAM_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cctd_pkg::REG_RPM_BOUNDS:  rpm_bounds     <= cfg_data;
        cctd_pkg::REG_LOAD_BOUNDS: load_bounds    <= cfg_data;
        cctd_pkg::REG_STALL:       stall_period   <= cfg_data[cctd_pkg::PERIOD_W-1:0];
        cctd_pkg::REG_DIVIDEND:    speed_dividend <= cfg_data[cctd_pkg::PERIOD_W-1:0];
        cctd_pkg::REG_CAM_GAP:     cam_gap_teeth  <= cfg_data[cctd_pkg::CAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd      <= s_tuser;
      item_period   <= s_tdata[15:0];
      item_throttle <= s_tdata[23:16];
      item_index    <= s_tdata[29:24];
      item_value    <= s_tdata[37:30];
    end
  end

  // Gap test, one-third scaling and tooth correction
  assign gap        = {1'b0, item_period} > {last_period, 1'b0};
  assign third_prod = (cctd_pkg::PERIOD_W + cctd_pkg::RECIP3_W)'(item_period)
                    * (cctd_pkg::PERIOD_W + cctd_pkg::RECIP3_W)'(cctd_pkg::RECIP3);
  assign period_new = gap ? third_prod[cctd_pkg::PERIOD_W+cctd_pkg::RECIP3_W-1:cctd_pkg::RECIP3_W]
                          : item_period;
  assign tooth_step = tooth_count + (gap ? 6'd2 : 6'd1);
  assign win_hit    = (tooth_step == cctd_pkg::TOOTH_WIN_A) ||
                      (tooth_step == cctd_pkg::TOOTH_WIN_B);

  always_comb begin
    tooth_fix = tooth_step;
    if ((tooth_step == cctd_pkg::TOOTH_BAD_A) || (tooth_step == cctd_pkg::TOOTH_BAD_B) ||
        (tooth_step == cctd_pkg::TOOTH_BAD_C)) begin
      tooth_fix = tooth_step + 6'd2;
    end
    tooth_new = (tooth_fix >= cctd_pkg::TOOTH_WRAP) ? '0 : tooth_fix;
  end

  assign divisor_upd = (item_cmd == cctd_pkg::CMD_CRANK) ? period_new : last_period;

  // Apply the event to the decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_count     <= '0;
      cam_count       <= '0;
      teeth_since_cam <= '0;
      last_period     <= '0;
      throttle_level  <= '0;
      window          <= 1'b0;
    end else if (cmd.update) begin
      window <= (item_cmd == cctd_pkg::CMD_CRANK) && win_hit;
      case (item_cmd)
        cctd_pkg::CMD_CRANK: begin
          tooth_count     <= tooth_new;
          teeth_since_cam <= teeth_since_cam + (gap ? 8'd2 : 8'd1);
          last_period     <= period_new;
        end
        cctd_pkg::CMD_CAM: begin
          cam_count       <= (teeth_since_cam > cam_gap_teeth) ? '0 : cam_count + 1'b1;
          teeth_since_cam <= '0;
        end
        cctd_pkg::CMD_THROTTLE: begin
          throttle_level <= item_throttle;
        end
        default: ;
      endcase
    end
  end

  // Speed divider, started as the new period is stored
  cctd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.update),
    .dividend (speed_dividend),
    .divisor  (divisor_upd),
    .done     (div_done),
    .quotient (quotient)
  );

  // Saturate speed; stalled wheel reads zero
  always_comb begin
    if (last_period >= stall_period) begin
      hertz_calc = '0;
    end else if (last_period == '0) begin
      hertz_calc = cctd_pkg::HERTZ_MAX;
    end else if (quotient[cctd_pkg::PERIOD_W-1:cctd_pkg::BYTE_W] != '0) begin
      hertz_calc = cctd_pkg::HERTZ_MAX;
    end else begin
      hertz_calc = quotient[cctd_pkg::BYTE_W-1:0];
    end
  end

  assign speed_band_next = pick_zone(rpm_bounds, hertz_calc, speed_band);
  assign load_band_next  = pick_zone(load_bounds, throttle_level, load_band);
  assign rd_addr         = {load_band_next, speed_band_next};

  // Cylinder selects from tooth and cam position
  always_comb begin
    ign_select_next = ign_select;
    inj_select_next = inj_select;
    if (tooth_count == cctd_pkg::TOOTH_IGN_A && cam_count == 8'd2) begin
      ign_select_next = 2'd0;
    end else if (tooth_count == cctd_pkg::TOOTH_IGN_A && cam_count == 8'd0) begin
      ign_select_next = 2'd1;
    end else if (tooth_count == cctd_pkg::TOOTH_IGN_B && cam_count == 8'd2) begin
      ign_select_next = 2'd2;
    end else if (tooth_count == cctd_pkg::TOOTH_IGN_B && cam_count == 8'd1) begin
      ign_select_next = 2'd3;
    end else if (tooth_count == cctd_pkg::TOOTH_INJ_A && cam_count == 8'd2) begin
      inj_select_next = 2'd0;
    end else if (tooth_count == cctd_pkg::TOOTH_INJ_A && cam_count == 8'd0) begin
      inj_select_next = 2'd1;
    end else if (tooth_count == cctd_pkg::TOOTH_INJ_B && cam_count == 8'd2) begin
      inj_select_next = 2'd2;
    end else if (tooth_count == cctd_pkg::TOOTH_INJ_B && cam_count == 8'd1) begin
      inj_select_next = 2'd3;
    end
  end

  // Update zones, speed and selects
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_band <= '0;
      load_band  <= '0;
      ign_select <= '0;
      inj_select <= '0;
      hertz      <= '0;
    end else if (cmd.zone) begin
      speed_band <= speed_band_next;
      load_band  <= load_band_next;
      ign_select <= ign_select_next;
      inj_select <= inj_select_next;
      hertz      <= hertz_calc;
    end
  end

  // Table valid bits: an unwritten entry reads zero
  always_ff @(posedge clk) begin
    if (rst) begin
      adv_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.update && item_cmd == cctd_pkg::CMD_TABLE) begin
        adv_valid[item_index] <= 1'b1;
      end
      if (cmd.zone) begin
        rd_valid <= adv_valid[rd_addr];
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.update && item_cmd == cctd_pkg::CMD_TABLE) begin
      adv_mem[item_index] <= item_value;
    end
    if (cmd.zone) begin
      rd_data <= adv_mem[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {7'd0, window, inj_select, ign_select,
                  (rd_valid ? rd_data : 8'd0), load_band, speed_band,
                  hertz, cam_count, tooth_count};
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = ~m_tvalid | m_tready;

endmodule

[design/crank_cam_trigger_decoder.sv]
// An accepted word passes through the update, divide, zone and emit states to its result on m_tvalid.
// Only one word is taken at a time, and the 16-step speed divider sets the pace.
// The output register holds a result while the next word is taken in.
// Reset (rst, synchronous, active high) clears all decoder state and the
// table valid bits, so every advance entry reads zero until written.
module crank_cam_trigger_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tooth_period[15:0], throttle_sample[23:16], table_index[29:24],
  // table_value[37:30], zero [39:38]
  input  logic [cctd_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [cctd_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tooth_number[5:0], cam_number[13:6], speed_hertz[21:14], speed_zone[24:22],
  // load_index[27:25], advance_degrees[35:28], spark_cylinder[37:36],
  // fuel_cylinder[39:38], spark_window_start[40], zero [47:41]
  output logic [cctd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [cctd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cctd_pkg::CFG_DATA_W-1:0] cfg_data
);

  cctd_pkg::cmd_t    cmd;
  cctd_pkg::status_t sts;

  // Sequencer
  cctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  cctd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[design/cctd_checker.sv]
// Port-level checker for the trigger decoder and its bind to the top level.
`include "assert_macros.svh"

module cctd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cctd_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word holds
  `CCTD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

  // One word at a time: busy right after an accept
  `CCTD_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "word taken while busy")

  // Tooth number always below the wrap point
  `CCTD_ASSERT(a_tooth_range, m_tvalid |-> m_tdata[5:0] < cctd_pkg::TOOTH_WRAP, "tooth number past wrap")

  // Spark window only at its two teeth
  `CCTD_ASSERT(a_window_tooth, m_tvalid && m_tdata[40] |-> m_tdata[5:0] == cctd_pkg::TOOTH_WIN_A || m_tdata[5:0] == cctd_pkg::TOOTH_WIN_B, "spark window at wrong tooth")

  // Reset empties the output register
  `CCTD_ASSERT_ALWAYS(a_reset_clears, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind crank_cam_trigger_decoder cctd_checker u_cctd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/tb_crank_cam_trigger_decoder.sv]
// Self-checking testbench for the crank and cam trigger decoder stream block.
`timescale 1ns / 100ps

module tb_crank_cam_trigger_decoder;

  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 225;
  localparam int STRESS_WORDS  = 560;
  localparam int SETTLE_CYCLES = 25;

  // One crank, cam, throttle or table event as it goes onto the input stream
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] period;
    logic [7:0]  throttle;
    logic [5:0]  index;
    logic [7:0]  value;
  } event_t;

  // One decoder reading as it comes off the output stream
  typedef struct packed {
    logic [5:0] tooth;
    logic [7:0] cam;
    logic [7:0] hertz;
    logic [2:0] speed_band;
    logic [2:0] load_band;
    logic [7:0] advance;
    logic [1:0] spark;
    logic [1:0] fuel;
    logic       window;
  } reading_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [cctd_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic [cctd_pkg::IN_USER_W-1:0]  s_tuser   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [cctd_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_we    = 1'b0;
  logic [cctd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cctd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  crank_cam_trigger_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder registers as the testbench last wrote them
  logic [63:0] rpm_bounds  = '0;
  logic [63:0] load_bounds = '0;
  logic [15:0] stall_per   = cctd_pkg::STALL_RESET;
  logic [15:0] dividend    = cctd_pkg::DIVIDEND_RESET;
  logic [7:0]  cam_gap     = cctd_pkg::CAM_GAP_RESET;

  // Decoder state as predicted
  logic [5:0]  tooth_cnt    = '0;
  logic [7:0]  cam_cnt      = '0;
  logic [7:0]  since_cam    = '0;
  logic [15:0] last_per     = '0;
  logic [7:0]  throttle_lvl = '0;
  logic [2:0]  speed_band   = '0;
  logic [2:0]  load_band    = '0;
  logic [1:0]  ign_sel      = '0;
  logic [1:0]  inj_sel      = '0;
  logic [7:0]  adv_table [cctd_pkg::TABLE_DEPTH];

  event_t   event_queue[$];
  reading_t expected_readings[$];
  event_t   drv_event;
  reading_t want;
  reading_t got;

  int  words_queued  = 0;
  int  words_sent    = 0;
  int  results_seen  = 0;
  int  errors        = 0;
  int  send_gap      = 0;
  int  recv_stall    = 0;
  int  gen_pos       = 0;
  int  settings_used = 1;
  int  window_cnt    = 0;
  int  gap_teeth     = 0;
  int  sat_cnt       = 0;
  int  stop_cnt      = 0;
  bit  no_idle       = 1'b0;

  initial begin
    foreach (adv_table[i]) adv_table[i] = '0;
  end

  // Lowest zone whose upper bound lies above the level; keep the old zone if none does
  function automatic logic [2:0] zone_of(logic [63:0] bounds, logic [7:0] level,
                                         logic [2:0] prev);
    logic [2:0] z;
    z = prev;
    for (int i = cctd_pkg::ZONE_COUNT - 1; i >= 0; i--)
      if (level < bounds[8*i +: 8]) z = 3'(i);
    return z;
  endfunction

  // Apply one event to the predicted state and return the reading it yields
  function automatic reading_t decode_event(event_t ev);
    reading_t r;
    int       t;
    int       p;
    int       q;
    logic [7:0] hz;
    r = '0;
    p = ev.period;
    case (ev.cmd)
      cctd_pkg::CMD_CRANK: begin
        t = tooth_cnt;
        if (p > 2 * last_per) begin
          // missing tooth: count two, keep a third of the period
          t += 2;
          since_cam += 8'd2;
          p = p / 3;
          gap_teeth++;
        end else begin
          t += 1;
          since_cam += 8'd1;
        end
        last_per = p[15:0];
        if (t == cctd_pkg::TOOTH_BAD_A || t == cctd_pkg::TOOTH_BAD_B ||
            t == cctd_pkg::TOOTH_BAD_C) t += 2;
        else if (t == cctd_pkg::TOOTH_WIN_A || t == cctd_pkg::TOOTH_WIN_B) r.window = 1'b1;
        if (t >= cctd_pkg::TOOTH_WRAP) t = 0;
        tooth_cnt = t[5:0];
      end
      cctd_pkg::CMD_CAM: begin
        cam_cnt += 8'd1;
        if (since_cam > cam_gap) cam_cnt = '0;
        since_cam = '0;
      end
      cctd_pkg::CMD_THROTTLE: throttle_lvl = ev.throttle;
      default: adv_table[ev.index] = ev.value;
    endcase

    // speed from the last tooth period
    if (last_per >= stall_per) begin
      hz = 8'd0;
    end else if (last_per == 16'd0) begin
      hz = cctd_pkg::HERTZ_MAX;
    end else begin
      q  = dividend / last_per;
      hz = (q > 255) ? cctd_pkg::HERTZ_MAX : q[7:0];
    end
    speed_band = zone_of(rpm_bounds, hz, speed_band);
    load_band  = zone_of(load_bounds, throttle_lvl, load_band);

    // cylinder selects from tooth and cam position
    if (tooth_cnt == cctd_pkg::TOOTH_IGN_A && cam_cnt == 8'd2)      ign_sel = 2'd0;
    else if (tooth_cnt == cctd_pkg::TOOTH_IGN_A && cam_cnt == 8'd0) ign_sel = 2'd1;
    else if (tooth_cnt == cctd_pkg::TOOTH_IGN_B && cam_cnt == 8'd2) ign_sel = 2'd2;
    else if (tooth_cnt == cctd_pkg::TOOTH_IGN_B && cam_cnt == 8'd1) ign_sel = 2'd3;
    else if (tooth_cnt == cctd_pkg::TOOTH_INJ_A && cam_cnt == 8'd2) inj_sel = 2'd0;
    else if (tooth_cnt == cctd_pkg::TOOTH_INJ_A && cam_cnt == 8'd0) inj_sel = 2'd1;
    else if (tooth_cnt == cctd_pkg::TOOTH_INJ_B && cam_cnt == 8'd2) inj_sel = 2'd2;
    else if (tooth_cnt == cctd_pkg::TOOTH_INJ_B && cam_cnt == 8'd1) inj_sel = 2'd3;

    r.tooth      = tooth_cnt;
    r.cam        = cam_cnt;
    r.hertz      = hz;
    r.speed_band = speed_band;
    r.load_band  = load_band;
    r.advance    = adv_table[{load_band, speed_band}];
    r.spark      = ign_sel;
    r.fuel       = inj_sel;
    if (r.window) window_cnt++;
    if (hz == cctd_pkg::HERTZ_MAX) sat_cnt++;
    if (hz == 8'd0) stop_cnt++;
    return r;
  endfunction

  function automatic reading_t from_bus(logic [cctd_pkg::OUT_DATA_W-1:0] d);
    reading_t r;
    r.tooth      = d[5:0];
    r.cam        = d[13:6];
    r.hertz      = d[21:14];
    r.speed_band = d[24:22];
    r.load_band  = d[27:25];
    r.advance    = d[35:28];
    r.spark      = d[37:36];
    r.fuel       = d[39:38];
    r.window     = d[40];
    return r;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  task automatic check_field(input string what, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, what, exp_val, act_val);
    end
  endtask

  // Driver: offer queued words, predict each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_readings.push_back(decode_event(drv_event));
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (event_queue.size() > 0) begin
          drv_event = event_queue.pop_front();
          send_gap  = pick_gap();
          s_tvalid <= 1'b1;
          s_tuser  <= drv_event.cmd;
          s_tdata  <= {2'b00, drv_event.value, drv_event.index,
                       drv_event.throttle, drv_event.period};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = from_bus(m_tdata);
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t ns: result word expected none actual %h", $time, m_tdata);
        end else begin
          want = expected_readings.pop_front();
          check_field("tooth_number", want.tooth, got.tooth);
          check_field("cam_number", want.cam, got.cam);
          check_field("speed_hertz", want.hertz, got.hertz);
          check_field("speed_zone", want.speed_band, got.speed_band);
          check_field("load_index", want.load_band, got.load_band);
          check_field("advance_degrees", want.advance, got.advance);
          check_field("spark_cylinder", want.spark, got.spark);
          check_field("fuel_cylinder", want.fuel, got.fuel);
          check_field("spark_window_start", want.window, got.window);
        end
        results_seen++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        recv_stall = pick_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic event_t rand_event(logic [1:0] cmd);
    event_t ev;
    ev.cmd      = cmd;
    ev.period   = 16'($urandom);
    ev.throttle = 8'($urandom);
    ev.index    = 6'($urandom);
    ev.value    = 8'($urandom);
    return ev;
  endfunction

  task automatic push_event(input event_t ev);
    event_queue.push_back(ev);
    words_queued++;
  endtask

  task automatic push_fields(input logic [1:0] cmd, input logic [15:0] period,
                             input logic [7:0] thr, input logic [5:0] idx,
                             input logic [7:0] val);
    event_t ev;
    ev = '{cmd: cmd, period: period, throttle: thr, index: idx, value: val};
    push_event(ev);
  endtask

  // Hold until every word has produced its result, then let the pipeline settle
  task automatic wait_idle();
    while (results_seen != words_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cctd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      cctd_pkg::REG_RPM_BOUNDS:  rpm_bounds  = val;
      cctd_pkg::REG_LOAD_BOUNDS: load_bounds = val;
      cctd_pkg::REG_STALL:       stall_per   = val[15:0];
      cctd_pkg::REG_DIVIDEND:    dividend    = val[15:0];
      cctd_pkg::REG_CAM_GAP:     cam_gap     = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rising_bounds();
    logic [63:0] b;
    int          acc;
    acc = 0;
    for (int i = 0; i < cctd_pkg::ZONE_COUNT; i++) begin
      acc += $urandom_range(1, 40);
      b[8*i +: 8] = (acc > 255) ? 8'd255 : 8'(acc);
    end
    return b;
  endfunction

  // Register setting for each phase; the extremes come in phases 1 to 3
  task automatic set_config(input int ph);
    logic [63:0] rb, lb;
    int          st, dv, cg;
    case (ph)
      0: begin
        rb = 64'hFF_E6_C8_A0_64_32_14_0A; lb = 64'hFF_E0_C0_A0_80_60_40_20;
        st = cctd_pkg::STALL_RESET; dv = cctd_pkg::DIVIDEND_RESET;
        cg = cctd_pkg::CAM_GAP_RESET;
      end
      1: begin
        rb = {$urandom, $urandom}; lb = {$urandom, $urandom};
        st = 65535; dv = 65535; cg = 255;
      end
      2: begin
        rb = '1; lb = '1; st = 1; dv = 1; cg = 0;
      end
      3: begin
        rb = '0; lb = '0;
        st = $urandom_range(1, 65535); dv = $urandom_range(1, 65535);
        cg = $urandom_range(0, 255);
      end
      4: begin
        rb = rising_bounds(); lb = rising_bounds();
        st = 20000; dv = cctd_pkg::DIVIDEND_RESET; cg = cctd_pkg::CAM_GAP_RESET;
      end
      default: begin
        rb = {$urandom, $urandom}; lb = rising_bounds();
        st = $urandom_range(1, 65535); dv = $urandom_range(1, 65535);
        cg = $urandom_range(0, 40);
      end
    endcase
    write_reg(cctd_pkg::REG_RPM_BOUNDS, rb);
    write_reg(cctd_pkg::REG_LOAD_BOUNDS, lb);
    write_reg(cctd_pkg::REG_STALL, 64'(st));
    write_reg(cctd_pkg::REG_DIVIDEND, 64'(dv));
    write_reg(cctd_pkg::REG_CAM_GAP, 64'(cg));
    no_idle = (ph == 2);
    settings_used++;
  endtask

  // Steady wheel run: even teeth, triple-length gap teeth, a sprinkling of other events
  task automatic push_wheel(input int n, input int cam_pct);
    event_t ev;
    int     base;
    int     r;
    case ($urandom_range(0, 3))
      0: base = $urandom_range(1, 300);
      1: base = $urandom_range(200, 2000);
      2: base = $urandom_range(2000, 12000);
      default: base = $urandom_range(8000, 20000);
    endcase
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < cam_pct) begin
        ev = rand_event(cctd_pkg::CMD_CAM);
      end else if (r < cam_pct + 3) begin
        ev = rand_event(cctd_pkg::CMD_THROTTLE);
      end else if (r < cam_pct + 5) begin
        ev = rand_event(cctd_pkg::CMD_TABLE);
      end else begin
        ev = rand_event(cctd_pkg::CMD_CRANK);
        if (r < cam_pct + 8) begin
          // broken tooth: leave the random period in place
        end else if (gen_pos == 11 || gen_pos == 14 || gen_pos == 29) begin
          ev.period = 16'(3 * base + $urandom_range(0, base / 4));
          gen_pos += 2;
        end else begin
          ev.period = 16'(base + $urandom_range(0, base / 8));
          gen_pos += 1;
        end
        if (gen_pos >= 36) gen_pos -= 36;
      end
      push_event(ev);
    end
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_event(rand_event(2'($urandom)));
  endtask

  task automatic fill_phase(input int budget);
    int target;
    target = words_queued + budget;
    while (words_queued < target) begin
      if ($urandom_range(0, 4) == 0) push_noise($urandom_range(5, 30));
      else push_wheel($urandom_range(20, 80), 6);
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero period, gap into stall, table edges
    push_fields(cctd_pkg::CMD_CRANK, 16'd0, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'hFFFF, 8'hFF, 6'h3F, 8'hFF);
    push_fields(cctd_pkg::CMD_CAM, 16'd0, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_THROTTLE, 16'd0, 8'hFF, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_TABLE, 16'd0, 8'd0, 6'h3F, 8'hFF);
    push_fields(cctd_pkg::CMD_TABLE, 16'hFFFF, 8'hFF, 6'h00, 8'h00);
    wait_idle();

    // graded zones: saturation, stall boundary, level above all bounds
    set_config(0);
    push_fields(cctd_pkg::CMD_TABLE, 16'd0, 8'd0, 6'd0, 8'h5A);
    push_fields(cctd_pkg::CMD_TABLE, 16'd0, 8'd0, 6'd9, 8'h21);
    push_fields(cctd_pkg::CMD_THROTTLE, 16'd0, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd1, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd0, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd3000, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd9999, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd6000, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd10000, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CAM, 16'd0, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CAM, 16'd0, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_THROTTLE, 16'd0, 8'hFF, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_CRANK, 16'd300, 8'd0, 6'd0, 8'd0);
    push_fields(cctd_pkg::CMD_TABLE, 16'd0, 8'd0, 6'h3F, 8'h80);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) set_config(ph);
      if (ph == 1) begin
        // wrap the cam count, then wrap the teeth-since-cam count before a pulse
        repeat (260) push_event(rand_event(cctd_pkg::CMD_CAM));
        push_wheel(270, 0);
        push_event(rand_event(cctd_pkg::CMD_CAM));
        fill_phase(STRESS_WORDS - 531);
      end else begin
        fill_phase(PHASE_WORDS);
      end
      wait_idle();
    end

    $display("Run covered %0d words over %0d register settings, %0d results checked.",
             words_sent, settings_used, results_seen);
    $display("Gap teeth %0d, spark windows %0d, saturated speed %0d, zero speed %0d.",
             gap_teeth, window_cnt, sat_cnt, stop_cnt);
    if (expected_readings.size() != 0) begin
      errors++;
      $display("%0t ns: results still outstanding expected 0 actual %0d",
               $time, expected_readings.size());
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
